// ----- src/pra_pkg.sv -----
// Shared types and constants for the pixel rotate / alpha flatten block.
package pra_pkg;

  localparam int unsigned COORD_W    = 12;
  localparam int unsigned SIDE_W     = 13;
  localparam int unsigned IDX_W      = 24;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned CFG_DATA_W = 13;

  // Pipeline depth shared by the coordinate path and the color path.
  localparam int unsigned NUM_STAGES = 5;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_QUARTER_TURNS = 2'd0;
  localparam cfg_idx_t CFG_WHITE_FILL    = 2'd1;
  localparam cfg_idx_t CFG_IMAGE_WIDTH   = 2'd2;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT  = 2'd3;

  typedef enum logic [1:0] {
    TURN_0   = 2'd0,
    TURN_90  = 2'd1,
    TURN_180 = 2'd2,
    TURN_270 = 2'd3
  } turn_e;

  typedef struct packed {
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [CHAN_W-1:0]  blue_in;
    logic [CHAN_W-1:0]  green_in;
    logic [CHAN_W-1:0]  red_in;
    logic [CHAN_W-1:0]  alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic [IDX_W-1:0]   dest_index;
    logic [CHAN_W-1:0]  blue_out;
    logic [CHAN_W-1:0]  green_out;
    logic [CHAN_W-1:0]  red_out;
    logic [CHAN_W-1:0]  alpha_out;
  } pix_out_t;

endpackage

// ----- src/pra_color.sv -----
// Color path: white compositing or rounded alpha unpremultiply, pipelined.
module pra_color (
  input  logic                                clk_i,
  input  logic [pra_pkg::NUM_STAGES-1:0]      stage_en_i,
  input  logic                                white_fill_i,
  input  pra_pkg::pix_in_t                    pix_i,
  output logic [pra_pkg::CHAN_W-1:0]          blue_o,
  output logic [pra_pkg::CHAN_W-1:0]          green_o,
  output logic [pra_pkg::CHAN_W-1:0]          red_o,
  output logic [pra_pkg::CHAN_W-1:0]          alpha_o
);
  import pra_pkg::*;

  localparam int unsigned NUM_CHAN   = 3;
  localparam int unsigned NUM_W      = 2 * CHAN_W + 1;    // c*255 + a/2
  localparam int unsigned DIV_STAGES = NUM_STAGES - 1;
  localparam int unsigned STEPS      = CHAN_W / DIV_STAGES; // quotient bits per stage
  localparam int unsigned LAST       = NUM_STAGES - 1;

  logic [CHAN_W-1:0] chan_in [NUM_CHAN];

  // Per-stage payload: partial remainder, partial quotient, bypass result.
  logic [NUM_W-1:0]  rem_q  [NUM_STAGES][NUM_CHAN];
  logic [CHAN_W-1:0] quo_q  [NUM_STAGES][NUM_CHAN];
  logic              byp_q  [NUM_STAGES][NUM_CHAN];
  logic [CHAN_W-1:0] bval_q [NUM_STAGES][NUM_CHAN];
  logic [CHAN_W-1:0] div_q  [NUM_STAGES];
  logic [CHAN_W-1:0] aout_q [NUM_STAGES];

  assign chan_in[0] = pix_i.blue_in;
  assign chan_in[1] = pix_i.green_in;
  assign chan_in[2] = pix_i.red_in;

  // Stage 0: numerator, saturation check, white composite.
  for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_entry
    logic [CHAN_W:0]   wsum;
    logic [CHAN_W-1:0] wsat;
    logic [NUM_W-1:0]  num;
    logic              sat;
    logic              zero_a;

    always_comb begin
      wsum   = {1'b0, chan_in[ch]} + {1'b0, {CHAN_W{1'b1}}} - {1'b0, pix_i.alpha_in};
      wsat   = wsum[CHAN_W] ? {CHAN_W{1'b1}} : wsum[CHAN_W-1:0];
      num    = {1'b0, chan_in[ch], {CHAN_W{1'b0}}} - NUM_W'(chan_in[ch])
               + NUM_W'(pix_i.alpha_in[CHAN_W-1:1]);
      // quotient would reach 256 or more
      sat    = num >= {1'b0, pix_i.alpha_in, {CHAN_W{1'b0}}};
      zero_a = pix_i.alpha_in == '0;
    end

    always_ff @(posedge clk_i) begin
      if (stage_en_i[0]) begin
        rem_q[0][ch]  <= num;
        quo_q[0][ch]  <= '0;
        byp_q[0][ch]  <= white_fill_i || zero_a || sat;
        bval_q[0][ch] <= white_fill_i ? wsat : (zero_a ? '0 : {CHAN_W{1'b1}});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      div_q[0]  <= pix_i.alpha_in;
      aout_q[0] <= white_fill_i ? {CHAN_W{1'b1}} : pix_i.alpha_in;
    end
  end

  // Restoring division, MSB first, STEPS quotient bits per stage.
  for (genvar s = 1; s < NUM_STAGES; s++) begin : g_div
    localparam int unsigned TOP_BIT = CHAN_W - 1 - (s - 1) * STEPS;

    for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_ch
      logic [NUM_W-1:0]  rem_v;
      logic [NUM_W-1:0]  dvs_v;
      logic [CHAN_W-1:0] quo_v;

      always_comb begin
        rem_v = rem_q[s-1][ch];
        quo_v = quo_q[s-1][ch];
        dvs_v = '0;
        for (int j = 0; j < STEPS; j++) begin
          dvs_v = NUM_W'(div_q[s-1]) << (TOP_BIT - j);
          if (rem_v >= dvs_v) begin
            rem_v = rem_v - dvs_v;
            quo_v = {quo_v[CHAN_W-2:0], 1'b1};
          end else begin
            quo_v = {quo_v[CHAN_W-2:0], 1'b0};
          end
        end
      end

      always_ff @(posedge clk_i) begin
        if (stage_en_i[s]) begin
          rem_q[s][ch]  <= rem_v;
          quo_q[s][ch]  <= quo_v;
          byp_q[s][ch]  <= byp_q[s-1][ch];
          bval_q[s][ch] <= bval_q[s-1][ch];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (stage_en_i[s]) begin
        div_q[s]  <= div_q[s-1];
        aout_q[s] <= aout_q[s-1];
      end
    end
  end

  assign blue_o  = byp_q[LAST][0] ? bval_q[LAST][0] : quo_q[LAST][0];
  assign green_o = byp_q[LAST][1] ? bval_q[LAST][1] : quo_q[LAST][1];
  assign red_o   = byp_q[LAST][2] ? bval_q[LAST][2] : quo_q[LAST][2];
  assign alpha_o = aout_q[LAST];

endmodule

// ----- src/pixel_rotate_alpha_flatten.sv -----
// Top level: quarter-turn pixel rotation with alpha flattening.
//
// Streams one premultiplied BGRA pixel per cycle, while in_stall_o is low,
// with its source column and row, and returns its destination column, row
// and linear index for a clockwise rotation of quarter_turns quarter turns,
// plus the converted color. Throughput is one item per clock when no stall
// holds it. The pipeline depth comes from the color path: the rounded
// unpremultiply (c*255 + a/2) / a is a restoring divider that resolves two
// quotient bits per stage over four stages, after one stage that forms the
// numerator. The coordinate path runs alongside: mux and subtract in stage 0,
// the row times output-width multiply in stage 1, the column add in stage 2.
// Every stage has its own valid bit and load enable, so bubbles collapse and
// in_stall_o rises only when all five stages hold items and out_stall_i is
// high; an item never drops or repeats under stall.
// Register map on the write port (cfg_idx_i): 0 quarter_turns (2 bits),
// 1 white_fill (1 bit), 2 image_width, 3 image_height (13 bits each, reset 1).
// A width or height of 0 acts as 1 and one above MAX_SIDE acts as MAX_SIDE.
// Write registers only while no item is in flight.
module pixel_rotate_alpha_flatten #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  pra_pkg::cfg_idx_t             cfg_idx_i,
  input  logic [pra_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pra_pkg::pix_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pra_pkg::pix_out_t             out_data_o
);
  import pra_pkg::*;

  localparam int unsigned LAST   = NUM_STAGES - 1;
  localparam int unsigned PROD_W = COORD_W + SIDE_W;

  // Configuration registers.
  turn_e             quarter_turns_q;
  logic              white_fill_q;
  logic [SIDE_W-1:0] image_width_q;
  logic [SIDE_W-1:0] image_height_q;

  // Pipeline control.
  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] stage_en;

  // Coordinate payload per stage. idx_q holds the product at stage 1
  // and the finished index from stage 2 on.
  logic [COORD_W-1:0] dx_q  [NUM_STAGES];
  logic [COORD_W-1:0] dy_q  [NUM_STAGES];
  logic [IDX_W-1:0]   idx_q [NUM_STAGES];
  logic [SIDE_W-1:0]  ow_q;

  logic [SIDE_W-1:0]          w_side;
  logic [SIDE_W-1:0]          h_side;
  logic [COORD_W-1:0]         hy;      // H-1-y, wraps mod 4096
  logic [COORD_W-1:0]         wx;      // W-1-x, wraps mod 4096
  logic [COORD_W-1:0]         dx_d;
  logic [COORD_W-1:0]         dy_d;
  logic [SIDE_W-1:0]          ow_d;
  logic [PROD_W-1:0]          prod;

  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] alpha;

  function automatic logic [SIDE_W-1:0] side_of(input logic [SIDE_W-1:0] v);
    if (v == '0) begin
      return SIDE_W'(1);
    end else if (32'(v) > MAX_SIDE) begin
      return SIDE_W'(MAX_SIDE);
    end else begin
      return v;
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quarter_turns_q <= TURN_0;
      white_fill_q    <= 1'b0;
      image_width_q   <= SIDE_W'(1);
      image_height_q  <= SIDE_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_QUARTER_TURNS: quarter_turns_q <= turn_e'(cfg_wdata_i[1:0]);
        CFG_WHITE_FILL:    white_fill_q    <= cfg_wdata_i[0];
        CFG_IMAGE_WIDTH:   image_width_q   <= cfg_wdata_i[SIDE_W-1:0];
        CFG_IMAGE_HEIGHT:  image_height_q  <= cfg_wdata_i[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Load enables: a stage loads when it is empty or its successor loads.
  always_comb begin
    stage_en[LAST] = !valid_q[LAST] || !out_stall_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
  end

  assign in_stall_o  = !stage_en[0];
  assign out_valid_o = valid_q[LAST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (stage_en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Stage 0: rotate coordinates and pick the output width.
  always_comb begin
    w_side = side_of(image_width_q);
    h_side = side_of(image_height_q);
    hy     = COORD_W'(h_side - SIDE_W'(1)) - in_data_i.src_y;
    wx     = COORD_W'(w_side - SIDE_W'(1)) - in_data_i.src_x;
    case (quarter_turns_q)
      TURN_90: begin
        dx_d = hy;
        dy_d = in_data_i.src_x;
        ow_d = h_side;
      end
      TURN_180: begin
        dx_d = wx;
        dy_d = hy;
        ow_d = w_side;
      end
      TURN_270: begin
        dx_d = in_data_i.src_y;
        dy_d = wx;
        ow_d = h_side;
      end
      default: begin
        dx_d = in_data_i.src_x;
        dy_d = in_data_i.src_y;
        ow_d = w_side;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      dx_q[0]  <= dx_d;
      dy_q[0]  <= dy_d;
      ow_q     <= ow_d;
      idx_q[0] <= '0;
    end
  end

  assign prod = PROD_W'(dy_q[0]) * PROD_W'(ow_q);

  for (genvar s = 1; s < NUM_STAGES; s++) begin : g_coord
    always_ff @(posedge clk_i) begin
      if (stage_en[s]) begin
        dx_q[s] <= dx_q[s-1];
        dy_q[s] <= dy_q[s-1];
        if (s == 1) begin
          idx_q[s] <= prod[IDX_W-1:0];
        end else if (s == 2) begin
          idx_q[s] <= idx_q[s-1] + IDX_W'(dx_q[s-1]);
        end else begin
          idx_q[s] <= idx_q[s-1];
        end
      end
    end
  end

  pra_color u_color (
    .clk_i        (clk_i),
    .stage_en_i   (stage_en),
    .white_fill_i (white_fill_q),
    .pix_i        (in_data_i),
    .blue_o       (blue),
    .green_o      (green),
    .red_o        (red),
    .alpha_o      (alpha)
  );

  always_comb begin
    out_data_o.dest_x     = dx_q[LAST];
    out_data_o.dest_y     = dy_q[LAST];
    out_data_o.dest_index = idx_q[LAST];
    out_data_o.blue_out   = blue;
    out_data_o.green_out  = green;
    out_data_o.red_out    = red;
    out_data_o.alpha_out  = alpha;
  end

endmodule
